### src/bgc_pkg.sv
// Shared types and constants for the button gesture classifier.
`timescale 1ns / 1ps

package bgc_pkg;

   // Widths of the configuration registers and the state counters.
   localparam int TICK_W  = 10;
   localparam int TIMER_W = 16;
   localparam int COUNT_W = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   typedef logic [1:0]         cls_type;
   typedef logic [1:0]         act_type;
   typedef logic [1:0]         ev_type;
   typedef logic [TIMER_W-1:0] timer_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [TICK_W-1:0]  tick_type;

   // Level classes.
   localparam cls_type CLS_LOW  = 2'd0;
   localparam cls_type CLS_HIGH = 2'd1;
   localparam cls_type CLS_RISE = 2'd2;
   localparam cls_type CLS_FALL = 2'd3;

   // Latched button actions.
   localparam act_type ACT_NONE    = 2'd0;
   localparam act_type ACT_PRESS   = 2'd1;
   localparam act_type ACT_RELEASE = 2'd2;

   // Gesture events.
   localparam ev_type EV_NONE  = 2'd0;
   localparam ev_type EV_CLICK = 2'd1;
   localparam ev_type EV_LONG  = 2'd2;
   localparam ev_type EV_MULTI = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_MS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_MS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_MS    = 2'd2;

   // Configuration reset values.
   localparam tick_type  TICK_MS_RST = 10'd10;
   localparam timer_type LONG_MS_RST = 16'd1000;
   localparam timer_type GAP_MS_RST  = 16'd300;

   // One result item.
   typedef struct packed {
      cls_type   level_class;
      ev_type    gesture;
      count_type click_count;
      logic      long_press_reached;
   } result_type;

endpackage

### src/button_gesture_classifier.sv
// Top level of the button gesture classifier: debounce window, action tracker and gesture timers.
`timescale 1ns / 1ps

//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------------
//  req     | in        | req_valid/ready    | req_level
//  rsp     | out       | rsp_valid/ready    | rsp_level_class, rsp_gesture, rsp_click_count,
//          |           |                    | rsp_long_press_reached
//  csr     | in        | csr_wr_en          | csr_index, csr_wdata
//
// One item is accepted per cycle unless the input register is full and the result waits; its
// result passes through the input register, then the classify and timer update logic into the
// result register. The state update for one item is registered together with its result as it
// moves from the input register to the result register, so the next item sees it right away.
// Reset clears the window, the timers, the counters and both stage valids, and restores
// the configuration defaults. While a result waits, the input register still takes one
// item and then holds it, so at most two items are in flight before the input stalls.
module button_gesture_classifier #(
   parameter int WINDOW_LEN = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_level,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_level_class,
   output logic [1:0]                         rsp_gesture,
   output logic [bgc_pkg::COUNT_W-1:0]        rsp_click_count,
   output logic                               rsp_long_press_reached,
   input  logic                               csr_wr_en,
   input  logic [bgc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bgc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int HALF    = WINDOW_LEN / 2;
   localparam int NEWER   = WINDOW_LEN - HALF;
   localparam int THR     = (HALF + 1) / 2;
   localparam int CNT_W   = $clog2(NEWER + 1);

   // Configuration registers.
   bgc_pkg::tick_type  tick_ms_ff;
   bgc_pkg::timer_type long_ms_ff;
   bgc_pkg::timer_type gap_ms_ff;

   // Pipeline control and payload.
   logic in_valid_ff;
   logic in_level_ff;
   logic rsp_valid_ff;
   bgc_pkg::result_type rsp_ff;
   bgc_pkg::result_type rsp_in;
   logic advance;

   // Classifier state.
   logic [WINDOW_LEN-1:0] window_ff;
   logic [WINDOW_LEN-1:0] window_in;
   bgc_pkg::cls_type   cls_ff;
   bgc_pkg::cls_type   cls_in;
   bgc_pkg::act_type   act_ff;
   bgc_pkg::act_type   act_in;
   bgc_pkg::timer_type press_ff;
   bgc_pkg::timer_type press_in;
   bgc_pkg::timer_type rel_ff;
   bgc_pkg::timer_type rel_in;
   bgc_pkg::count_type clicks_ff;
   bgc_pkg::count_type clicks_in;
   logic               clicking_ff;
   logic               clicking_in;

   // Intermediate values.
   logic [CNT_W-1:0]   older_ones;
   logic [CNT_W-1:0]   newer_ones;
   logic               older_hi;
   logic               newer_hi;
   bgc_pkg::act_type   act_mid;
   logic [bgc_pkg::TIMER_W:0] press_sum;
   logic [bgc_pkg::TIMER_W:0] rel_sum;
   bgc_pkg::timer_type press_sat;
   bgc_pkg::timer_type rel_sat;
   bgc_pkg::count_type clicks_inc;

   // Handshake: the compute stage moves whenever the result register is free or drained.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_level_ff <= req_level;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ms_ff <= bgc_pkg::TICK_MS_RST;
         long_ms_ff <= bgc_pkg::LONG_MS_RST;
         gap_ms_ff  <= bgc_pkg::GAP_MS_RST;
      end else if (csr_wr_en) begin
         if (csr_index == bgc_pkg::CSR_TICK_MS) begin
            tick_ms_ff <= csr_wdata[bgc_pkg::TICK_W-1:0];
         end
         if (csr_index == bgc_pkg::CSR_LONG_MS) begin
            long_ms_ff <= csr_wdata;
         end
         if (csr_index == bgc_pkg::CSR_GAP_MS) begin
            gap_ms_ff <= csr_wdata;
         end
      end
   end

   // Shift the new sample in and vote on each half of the window.
   always_comb begin
      window_in  = {in_level_ff, window_ff[WINDOW_LEN-1:1]};
      older_ones = '0;
      newer_ones = '0;
      for (int i = 0; i < HALF; i++) begin
         older_ones = older_ones + CNT_W'(window_in[i]);
      end
      for (int i = HALF; i < WINDOW_LEN; i++) begin
         newer_ones = newer_ones + CNT_W'(window_in[i]);
      end
      older_hi = (older_ones >= CNT_W'(THR));
      newer_hi = (newer_ones >= CNT_W'(THR));
      if (older_hi == newer_hi) begin
         cls_in = older_hi ? bgc_pkg::CLS_HIGH : bgc_pkg::CLS_LOW;
      end else begin
         cls_in = older_hi ? bgc_pkg::CLS_FALL : bgc_pkg::CLS_RISE;
      end
   end

   // Saturating timer sums and click increment.
   always_comb begin
      press_sum  = {1'b0, press_ff} + {{(bgc_pkg::TIMER_W + 1 - bgc_pkg::TICK_W){1'b0}},
                                       tick_ms_ff};
      rel_sum    = {1'b0, rel_ff} + {{(bgc_pkg::TIMER_W + 1 - bgc_pkg::TICK_W){1'b0}},
                                     tick_ms_ff};
      press_sat  = press_sum[bgc_pkg::TIMER_W] ? '1 : press_sum[bgc_pkg::TIMER_W-1:0];
      rel_sat    = rel_sum[bgc_pkg::TIMER_W] ? '1 : rel_sum[bgc_pkg::TIMER_W-1:0];
      clicks_inc = (clicks_ff == '1) ? clicks_ff : clicks_ff + 1'b1;
   end

   // Action tracking and gesture decision.
   always_comb begin
      priority if (cls_ff == bgc_pkg::CLS_RISE && cls_in == bgc_pkg::CLS_HIGH) begin
         act_mid = bgc_pkg::ACT_PRESS;
      end else if (cls_ff == bgc_pkg::CLS_HIGH && cls_in == bgc_pkg::CLS_FALL) begin
         act_mid = bgc_pkg::ACT_RELEASE;
      end else begin
         act_mid = act_ff;
      end

      act_in      = act_mid;
      press_in    = press_ff;
      rel_in      = rel_ff;
      clicks_in   = clicks_ff;
      clicking_in = clicking_ff;
      rsp_in.level_class        = cls_in;
      rsp_in.gesture            = bgc_pkg::EV_NONE;
      rsp_in.click_count        = '0;
      rsp_in.long_press_reached = 1'b0;

      priority if (act_mid == bgc_pkg::ACT_PRESS) begin
         rsp_in.long_press_reached = (press_sat == long_ms_ff);
         if (clicking_ff) begin
            clicks_in   = clicks_inc;
            clicking_in = 1'b0;
            press_in    = '0;
            rel_in      = '0;
         end else begin
            press_in = press_sat;
         end
      end else if (act_mid == bgc_pkg::ACT_RELEASE) begin
         if (press_ff > long_ms_ff) begin
            // A press held past the limit ends as a long press.
            rsp_in.gesture = bgc_pkg::EV_LONG;
            act_in         = bgc_pkg::ACT_NONE;
            press_in       = '0;
         end else if (rel_sat > gap_ms_ff && clicks_ff == '0) begin
            // Gap closed after a lone click.
            rsp_in.gesture = bgc_pkg::EV_CLICK;
            act_in         = bgc_pkg::ACT_NONE;
            press_in       = '0;
            rel_in         = '0;
            clicking_in    = 1'b0;
         end else if (rel_sat > gap_ms_ff) begin
            // Gap closed after several clicks.
            rsp_in.gesture     = bgc_pkg::EV_MULTI;
            rsp_in.click_count = clicks_inc;
            act_in             = bgc_pkg::ACT_NONE;
            press_in           = '0;
            rel_in             = '0;
            clicks_in          = '0;
            clicking_in        = 1'b0;
         end else begin
            rel_in      = rel_sat;
            clicking_in = 1'b1;
         end
      end else begin
         act_in = act_mid;
      end
   end

   // State and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         window_ff    <= '0;
         cls_ff       <= bgc_pkg::CLS_LOW;
         act_ff       <= bgc_pkg::ACT_NONE;
         press_ff     <= '0;
         rel_ff       <= '0;
         clicks_ff    <= '0;
         clicking_ff  <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            window_ff   <= window_in;
            cls_ff      <= cls_in;
            act_ff      <= act_in;
            press_ff    <= press_in;
            rel_ff      <= rel_in;
            clicks_ff   <= clicks_in;
            clicking_ff <= clicking_in;
         end
      end
      if (advance && in_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_level_class        = rsp_ff.level_class;
   assign rsp_gesture            = rsp_ff.gesture;
   assign rsp_click_count        = rsp_ff.click_count;
   assign rsp_long_press_reached = rsp_ff.long_press_reached;

endmodule
